// File: hdl/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants for the TLV stream deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CNT_W     = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ROLE_TYPE   = 2'd0,
    ROLE_LEN_LO = 2'd1,
    ROLE_LEN_HI = 2'd2,
    ROLE_VALUE  = 2'd3
  } role_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_payload;
  } in_item_t;

  typedef struct packed {
    role_t             byte_role;
    logic [BYTE_W-1:0] record_type;
    logic [LEN_W-1:0]  record_length;
    logic [BYTE_W-1:0] value_byte;
    logic [LEN_W-1:0]  value_offset;
    logic              record_complete;
    logic [CNT_W-1:0]  record_count;
    logic              payload_end;
    logic              truncated;
  } result_t;

endpackage

// File: hdl/tsd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_in_stage
// Input register: captures one byte transfer per cycle, holds it under stall.
// ----------------------------------------------------------------------------
module tsd_in_stage import tsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output in_item_t out_item
);

  logic     valid;
  in_item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// File: hdl/tsd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_parse
// Record parser state and result register; one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tsd_parse import tsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  role_t             phase, phase_next;
  logic [BYTE_W-1:0] held_type, held_type_next;
  logic [LEN_W-1:0]  held_length, held_length_next;
  logic [LEN_W-1:0]  value_index, value_index_next;
  logic [CNT_W-1:0]  done_records, done_records_next;
  logic [LEN_W-1:0]  index_inc;
  logic [LEN_W-1:0]  len_full;
  logic              complete;
  result_t           res, res_next;
  logic              valid;
  logic              take;

  assign in_ready  = !valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid;
  assign out_res   = res;

  assign index_inc = value_index + LEN_W'(1);
  assign len_full  = {in_item.data_byte, held_length[BYTE_W-1:0]};

  always_comb begin
    phase_next        = phase;
    held_type_next    = held_type;
    held_length_next  = held_length;
    value_index_next  = value_index;
    complete          = 1'b0;
    res_next          = '0;
    res_next.byte_role = phase;
    unique case (phase)
      ROLE_TYPE: begin
        held_type_next   = in_item.data_byte;
        held_length_next = '0;
        value_index_next = '0;
        phase_next       = ROLE_LEN_LO;
      end
      ROLE_LEN_LO: begin
        held_length_next = {{(LEN_W-BYTE_W){1'b0}}, in_item.data_byte};
        phase_next       = ROLE_LEN_HI;
      end
      ROLE_LEN_HI: begin
        held_length_next       = len_full;
        res_next.record_length = len_full;
        value_index_next       = '0;
        if (len_full == '0) begin
          complete   = 1'b1;
          phase_next = ROLE_TYPE;
        end else begin
          phase_next = ROLE_VALUE;
        end
      end
      ROLE_VALUE: begin
        res_next.record_length = held_length;
        res_next.value_byte    = in_item.data_byte;
        res_next.value_offset  = value_index;
        value_index_next       = index_inc;
        if (index_inc == held_length) begin
          complete   = 1'b1;
          phase_next = ROLE_TYPE;
        end
      end
      default: phase_next = ROLE_TYPE;
    endcase

    done_records_next = done_records;
    if (complete && done_records != COUNT_MAX) begin
      done_records_next = done_records + CNT_W'(1);
    end

    res_next.record_type     = held_type_next;
    res_next.record_complete = complete;
    res_next.record_count    = done_records_next;
    res_next.payload_end     = in_item.last_of_payload;
    res_next.truncated       = in_item.last_of_payload && (phase_next != ROLE_TYPE);

    if (in_item.last_of_payload) begin
      phase_next        = ROLE_TYPE;
      held_type_next    = '0;
      held_length_next  = '0;
      value_index_next  = '0;
      done_records_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      phase        <= ROLE_TYPE;
      held_type    <= '0;
      held_length  <= '0;
      value_index  <= '0;
      done_records <= '0;
    end else begin
      if (in_ready) begin
        valid <= in_valid;
      end
      if (take) begin
        phase        <= phase_next;
        held_type    <= held_type_next;
        held_length  <= held_length_next;
        value_index  <= value_index_next;
        done_records <= done_records_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

// File: hdl/tlv_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_stream_deframer
// Splits a byte stream into type / 16-bit LE length / value records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one payload byte per transfer; s_axis_tlast marks the
//   last byte of a payload. m_axis returns one result per byte: role, record
//   type, length, value byte and offset, completion flag and running record
//   count. m_axis_tlast echoes the payload end; m_axis_tuser is set on that
//   last result when a record was left open, and downstream must drop the
//   bytes of that unfinished record.
//   From input transfer to result valid: input register, then result register.
//   Throughput: one byte per cycle while m_axis is not stalled; the parser state
//   update is a single compare and increment per byte.
//   Reset clears both stages and returns the parser to expecting a type byte
//   with a zero record count. The parser also returns there after every
//   payload end.
//   When the receiver stalls, the result register holds and the input
//   register keeps accepting until it is full; s_axis_tready then drops.
// ----------------------------------------------------------------------------
module tlv_stream_deframer import tsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                  s_axis_tlast,  // last_of_payload
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] byte_role, [9:2] record_type, [25:10] record_length,
  // [33:26] value_byte, [49:34] value_offset, [50] record_complete,
  // [66:51] record_count, [71:67] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,  // payload_end
  output logic                  m_axis_tuser   // truncated
);

  in_item_t s_item;
  in_item_t reg_item;
  logic     reg_valid;
  logic     reg_ready;
  result_t  res;

  assign s_item.data_byte       = s_axis_tdata;
  assign s_item.last_of_payload = s_axis_tlast;

  tsd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (s_item),
    .out_valid (reg_valid),
    .out_ready (reg_ready),
    .out_item  (reg_item)
  );

  tsd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (reg_valid),
    .in_ready  (reg_ready),
    .in_item   (reg_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {5'b0, res.record_count, res.record_complete, res.value_offset,
                         res.value_byte, res.record_length, res.record_type,
                         res.byte_role};
  assign m_axis_tlast = res.payload_end;
  assign m_axis_tuser = res.truncated;

  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.truncated |-> res.payload_end)
    else $error("truncated flag without payload end");

  a_complete_role: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.record_complete |->
      (res.byte_role == ROLE_LEN_HI) || (res.byte_role == ROLE_VALUE))
    else $error("record completed on a header byte");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.byte_role == ROLE_LEN_HI && res.record_length != '0 |->
      !res.record_complete)
    else $error("non-empty record completed at length byte");

  a_value_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.byte_role == ROLE_VALUE && res.record_complete |->
      (res.value_offset + LEN_W'(1)) == res.record_length)
    else $error("record completed at wrong offset");

endmodule

// File: test/tlv_stream_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_stream_deframer_tb
// Self-checking bench for the TLV stream deframer. A directed set of short
// payloads covers zero-length records, field extremes and truncation in each
// parser phase. Random payloads of well-formed records (plus noise and cut
// tails) follow. Every input transfer is run through a local parser model,
// and each output transfer is checked field by field against the oldest
// prediction. The sender idles in random bursts, the receiver stalls on its
// own run-length pattern and holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_tb;
  import tsd_pkg::*;

  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOLD_CYCLES    = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  tlv_stream_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  in_item_t         pending_bytes[$];
  result_t          expected_results[$];
  logic [BYTE_W-1:0] frame_bytes[$];

  // parser model state
  role_t            parse_phase;
  logic [BYTE_W-1:0] cur_type;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  val_idx;
  logic [CNT_W-1:0]  rec_done;

  int        mismatches = 0;
  int        gap_left   = 0;
  int        burst_left = 0;
  int        ready_left = 0;
  int        stall_left = 0;
  int        hold_left  = 0;
  longint    cycle_count = 0;
  in_item_t  next_item;
  result_t   seen;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_parser();
    parse_phase = ROLE_TYPE;
    cur_type    = '0;
    cur_len     = '0;
    val_idx     = '0;
    rec_done    = '0;
  endfunction

  function automatic result_t parse_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t r;
    r             = '0;
    r.byte_role   = parse_phase;
    r.payload_end = last;
    case (parse_phase)
      ROLE_TYPE: begin
        cur_type    = b;
        cur_len     = '0;
        val_idx     = '0;
        parse_phase = ROLE_LEN_LO;
      end
      ROLE_LEN_LO: begin
        cur_len     = {8'h00, b};
        parse_phase = ROLE_LEN_HI;
      end
      ROLE_LEN_HI: begin
        cur_len         = {b, cur_len[7:0]};
        r.record_length = cur_len;
        val_idx         = '0;
        if (cur_len == '0) begin
          r.record_complete = 1'b1;
          if (rec_done != COUNT_MAX) rec_done++;
          parse_phase = ROLE_TYPE;
        end else begin
          parse_phase = ROLE_VALUE;
        end
      end
      default: begin
        r.record_length = cur_len;
        r.value_byte    = b;
        r.value_offset  = val_idx;
        val_idx++;
        if (val_idx == cur_len) begin
          r.record_complete = 1'b1;
          if (rec_done != COUNT_MAX) rec_done++;
          parse_phase = ROLE_TYPE;
        end
      end
    endcase
    r.record_type  = cur_type;
    r.record_count = rec_done;
    if (last) begin
      r.truncated = (parse_phase != ROLE_TYPE);
      clear_parser();
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d at %0t: %s expected 0x%0h, got 0x%0h",
                 mismatches, $realtime, name, exp_v, act_v);
    end
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
    in_item_t it;
    it.data_byte       = b;
    it.last_of_payload = last;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  task automatic add_frame_byte(input logic [BYTE_W-1:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  // header plus nvals random value bytes into the payload under construction
  task automatic add_record(input logic [BYTE_W-1:0] typ, input int unsigned len,
                            input int unsigned nvals);
    logic [LEN_W-1:0] l16;
    l16 = len[LEN_W-1:0];
    add_frame_byte(typ);
    add_frame_byte(l16[7:0]);
    add_frame_byte(l16[15:8]);
    repeat (nvals) add_frame_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic flush_payload();
    foreach (frame_bytes[i]) queue_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  function automatic int unsigned pick_len(input bit allow_huge);
    int unsigned m;
    m = $urandom_range(0, 99);
    if (m < 15) return 0;
    if (m < 85) return $urandom_range(1, 12);
    if (m < 97 || !allow_huge) return $urandom_range(13, 300);
    return $urandom_range(301, 65535);
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left   = 0;
      burst_left = $urandom_range(1, 40);
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(),
                                parse_byte(s_axis_tdata, s_axis_tlast));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || pending_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          next_item = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data_byte;
          s_axis_tlast  <= next_item.last_of_payload;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // long receiver hold-offs while the sender keeps going
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (cycle_count == 400 || cycle_count == 1500)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // receiver: check each output transfer, then pick the next ready value
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d at %0t: result with nothing pending, tdata 0x%0h",
                     mismatches, $realtime, m_axis_tdata);
        end else begin
          seen = expected_results.pop_front();
          check_field("byte_role",       seen.byte_role,       m_axis_tdata[1:0]);
          check_field("record_type",     seen.record_type,     m_axis_tdata[9:2]);
          check_field("record_length",   seen.record_length,   m_axis_tdata[25:10]);
          check_field("value_byte",      seen.value_byte,      m_axis_tdata[33:26]);
          check_field("value_offset",    seen.value_offset,    m_axis_tdata[49:34]);
          check_field("record_complete", seen.record_complete, m_axis_tdata[50]);
          check_field("record_count",    seen.record_count,    m_axis_tdata[66:51]);
          check_field("tdata padding",   0,                    m_axis_tdata[71:67]);
          check_field("payload_end",     seen.payload_end,     m_axis_tlast);
          check_field("truncated",       seen.truncated,       m_axis_tuser);
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (ready_left != 0) begin
        ready_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        ready_left = $urandom_range(1, 24);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned nvals;
    int unsigned nrec;
    int unsigned lim;
    clear_parser();

    // zero-length record, then extreme type bytes with a completing value
    add_record(8'h00, 0, 0);
    add_record(8'hFF, 1, 1);
    flush_payload();
    // payload ending on a zero-length record's length high byte
    add_record(8'hA5, 0, 0);
    flush_payload();
    // open record at payload end: after type, after length low,
    // after length high (max length), and in the middle of the value
    queue_byte(8'h5A, 1'b1);
    add_record(8'h81, 7, 0);
    void'(frame_bytes.pop_back());
    flush_payload();
    add_record(8'h7E, 65535, 0);
    flush_payload();
    add_record(8'h3C, 4, 2);
    flush_payload();

    while (pending_bytes.size() < RANDOM_ITEMS + 21) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20))
          queue_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        nrec = $urandom_range(0, 6);
        repeat (nrec) begin
          len = pick_len(1'b0);
          add_record(BYTE_W'($urandom_range(0, 255)), len, len);
        end
        if (nrec == 0 || $urandom_range(0, 4) == 0) begin
          len = pick_len(1'b1);
          if (len == 0) begin
            nvals = 0;
          end else begin
            lim   = (len - 1 < 40) ? len - 1 : 40;
            nvals = $urandom_range(0, lim);
          end
          add_record(BYTE_W'($urandom_range(0, 255)), len, nvals);
          if (nvals == 0) repeat ($urandom_range(0, 2)) void'(frame_bytes.pop_back());
        end
        flush_payload();
      end
    end

    @(posedge clk);
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_results.size());
    end
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
